// ===== rtl/frt_pkg.sv =====
`default_nettype none
package frt_pkg;

	localparam int CONTEXTS_DEF = 16;
	localparam int MAX_FRAGS_DEF = 64;
	localparam int TIMEOUT_SECONDS = 10;
	localparam int TICKS_PER_SECOND = 1000;
	localparam logic [15:0] TIMEOUT_RESET = 16'(TIMEOUT_SECONDS * TICKS_PER_SECOND);
	localparam int BITMAP_BITS = 64;

	localparam logic [3:0] ST_SINGLE        = 4'd0;
	localparam logic [3:0] ST_BAD_NUMBER    = 4'd1;
	localparam logic [3:0] ST_NOT_FIRST     = 4'd2;
	localparam logic [3:0] ST_TOO_MANY      = 4'd3;
	localparam logic [3:0] ST_TABLE_FULL    = 4'd4;
	localparam logic [3:0] ST_BUFFERED      = 4'd5;
	localparam logic [3:0] ST_COMPLETE_OK   = 4'd6;
	localparam logic [3:0] ST_COMPLETE_FAIL = 4'd7;
	localparam logic [3:0] ST_TICK          = 4'd8;

	typedef struct packed {
		logic        mode;
		logic [31:0] identity;
		logic [7:0]  fragment_no;
		logic [7:0]  total_fragments;
		logic [15:0] fragment_size;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [31:0] pkt_id;
		logic [21:0] packet_size;
		logic [4:0]  expired_count;
	} out_item_t;

	// one context entry as held in the context memory
	typedef struct packed {
		logic [31:0] identity;
		logic [6:0]  expected;
		logic [6:0]  count;
		logic [21:0] size_sum;
		logic [63:0] seen_map;
		logic        bad;
		logic [15:0] age;
	} ctx_t;

	localparam int CTX_W = $bits(ctx_t);

endpackage
`default_nettype wire

// ===== rtl/fragment_reassembly_tracker.sv =====
// A tick visits every context in a read state and a write state (S_TICKR,
// S_TICKW); a fragment needing the context lookup passes S_SCAN, S_WAIT and
// S_OUT, then S_FRAG when it updates a hit; for a single or badly numbered
// fragment out_valid rises at the accepting edge. One item at a time: input
// stalls until the result has transferred; the identity scan sets the rate.
// Reset clears valid bits and the handshake state; timeout returns to 10000.
`default_nettype none
module fragment_reassembly_tracker
	import frt_pkg::*;
#(
	parameter int CONTEXTS = CONTEXTS_DEF,
	parameter int MAX_FRAGS = MAX_FRAGS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_item_t  in_data,
	input  wire logic      in_valid,
	output logic           in_stall,
	output out_item_t      out_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	input  wire logic [15:0] cfg_data,
	input  wire logic      cfg_valid,
	output logic           cfg_ready
);
	localparam int AW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;

	logic [15:0]   timeout_q;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	ctx_t          ram_wdata, ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			timeout_q <= TIMEOUT_RESET;
		else if (cfg_valid && cfg_ready)
			timeout_q <= cfg_data;
	end

	frt_ctrl #(.CONTEXTS(CONTEXTS), .MAX_FRAGS(MAX_FRAGS)) u_ctrl (
		.clk, .arst_n, .in_data, .in_valid, .in_stall,
		.out_data, .out_valid, .out_stall, .timeout_q,
		.ram_we, .ram_waddr, .ram_wdata, .ram_raddr, .ram_rdata
	);

	frt_ram #(.WIDTH(CTX_W), .DEPTH(1 << AW)) u_ctx_ram (
		.clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);
endmodule
`default_nettype wire

// ===== rtl/frt_ram.sv =====
`default_nettype none
module frt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/frt_ctrl.sv =====
`default_nettype none
module frt_ctrl
	import frt_pkg::*;
#(
	parameter int CONTEXTS = CONTEXTS_DEF,
	parameter int MAX_FRAGS = MAX_FRAGS_DEF,
	localparam int AW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_item_t  in_data,
	input  wire logic      in_valid,
	output logic           in_stall,
	output out_item_t      out_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	input  wire logic [15:0] timeout_q,
	output logic           ram_we,
	output logic [AW-1:0]  ram_waddr,
	output ctx_t           ram_wdata,
	output logic [AW-1:0]  ram_raddr,
	input  wire ctx_t      ram_rdata
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_WAIT  = 3'd2;
	localparam logic [2:0] S_FRAG  = 3'd3;
	localparam logic [2:0] S_TICKR = 3'd4;
	localparam logic [2:0] S_TICKW = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]          state_q;
	in_item_t            item_q;
	logic [CONTEXTS-1:0] valid_q;
	logic [AW:0]         idx_q;
	logic [4:0]          freed_q;
	out_item_t           res_q;
	logic                res_v_q;

	logic [CONTEXTS-1:0] ident_hit_q;
	logic [AW-1:0]       hit_idx, free_idx;
	logic                hit_any, free_any;
	logic [AW-1:0]       sel_q;

	// identity of every entry is matched by reading the memory one entry a cycle
	// during the scan into the match vector; the lowest live hit and free entry win
	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		free_any = 1'b0;
		free_idx = '0;
		for (int i = CONTEXTS - 1; i >= 0; i--) begin
			if (ident_hit_q[i] && valid_q[i]) begin
				hit_any = 1'b1;
				hit_idx = AW'(i);
			end
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = AW'(i);
			end
		end
	end

	logic last_idx;
	assign last_idx = (idx_q == (AW+1)'(CONTEXTS - 1));

	assign in_stall = (state_q != S_IDLE) || res_v_q;
	assign out_data = res_q;
	assign out_valid = res_v_q;
	assign ram_raddr = (state_q == S_IDLE) ? '0 :
		(state_q == S_FRAG || state_q == S_WAIT) ? sel_q : idx_q[AW-1:0];

	// fragment read-modify-write
	ctx_t          upd;
	logic          bad_no;
	logic [63:0]   bit_m;
	logic [6:0]    cnt_n;
	logic [21:0]   sum_n;
	always_comb begin
		upd = ram_rdata;
		bad_no = (item_q.fragment_no == 8'd0) ||
			(item_q.fragment_no > {1'b0, ram_rdata.expected}) ||
			(item_q.fragment_no > 8'(BITMAP_BITS));
		bit_m = 64'd1 << item_q.fragment_no[5:0] - 6'd1;
		if (bad_no)
			upd.bad = 1'b1;
		else begin
			if ((ram_rdata.seen_map & bit_m) != '0)
				upd.bad = 1'b1;
			upd.seen_map = ram_rdata.seen_map | bit_m;
		end
		cnt_n = ram_rdata.count + 7'd1;
		sum_n = ram_rdata.size_sum + 22'(item_q.fragment_size);
		upd.count = cnt_n;
		upd.size_sum = sum_n;
	end

	logic [15:0] age_n;
	assign age_n = (ram_rdata.age != 16'hFFFF) ? ram_rdata.age + 16'd1 : ram_rdata.age;

	ctx_t new_ctx;
	always_comb begin
		new_ctx.identity = item_q.identity;
		new_ctx.expected = item_q.total_fragments[6:0];
		new_ctx.count = 7'd1;
		new_ctx.size_sum = 22'(item_q.fragment_size);
		new_ctx.seen_map = 64'd1;
		new_ctx.bad = 1'b0;
		new_ctx.age = '0;
	end

	// a first fragment with no context takes the lowest free entry
	logic alloc;
	assign alloc = !hit_any && (item_q.fragment_no == 8'd1) &&
		(item_q.total_fragments <= 8'(MAX_FRAGS)) && free_any;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = sel_q;
		ram_wdata = upd;
		unique case (state_q)
			// write back only once the entry's read has landed
			S_FRAG: ram_we = (idx_q != '0);
			S_TICKW: begin
				ram_we = valid_q[idx_q[AW-1:0]];
				ram_waddr = idx_q[AW-1:0];
				ram_wdata = ram_rdata;
				ram_wdata.age = age_n;
			end
			S_OUT: begin
				ram_we = alloc;
				ram_waddr = free_idx;
				ram_wdata = new_ctx;
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			idx_q <= '0;
			freed_q <= '0;
			res_v_q <= 1'b0;
			ident_hit_q <= '0;
			sel_q <= '0;
		end else begin
			if (res_v_q && !out_stall)
				res_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						item_q <= in_data;
						idx_q <= '0;
						freed_q <= '0;
						ident_hit_q <= '0;
						if (in_data.mode)
							state_q <= S_TICKR;
						else if (in_data.total_fragments <= 8'd1) begin
							res_q <= '{ST_SINGLE, in_data.identity,
								22'(in_data.fragment_size), 5'd0};
							res_v_q <= 1'b1;
						end else if (in_data.fragment_no > in_data.total_fragments) begin
							res_q <= '{ST_BAD_NUMBER, in_data.identity,
								22'(in_data.fragment_size), 5'd0};
							res_v_q <= 1'b1;
						end else
							state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// read address idx_q issued; data arrives next cycle
					idx_q <= idx_q + 1'b1;
					if (idx_q != '0)
						ident_hit_q[idx_q[AW-1:0] - 1'b1] <=
							(ram_rdata.identity == item_q.identity);
					if (last_idx)
						state_q <= S_WAIT;
				end
				S_WAIT: begin
					ident_hit_q[CONTEXTS-1] <= (ram_rdata.identity == item_q.identity);
					state_q <= S_OUT;
					sel_q <= '0;
				end
				S_OUT: begin
					// decide; a write here only lands for a new context
					if (hit_any) begin
						sel_q <= hit_idx;
						state_q <= S_FRAG;
						idx_q <= '0;
					end else begin
						state_q <= S_IDLE;
						res_v_q <= 1'b1;
						if (item_q.fragment_no != 8'd1)
							res_q <= '{ST_NOT_FIRST, item_q.identity,
								22'(item_q.fragment_size), 5'd0};
						else if (item_q.total_fragments > 8'(MAX_FRAGS))
							res_q <= '{ST_TOO_MANY, item_q.identity,
								22'(item_q.fragment_size), 5'd0};
						else if (!free_any)
							res_q <= '{ST_TABLE_FULL, item_q.identity,
								22'(item_q.fragment_size), 5'd0};
						else begin
							valid_q[free_idx] <= 1'b1;
							res_q <= '{ST_BUFFERED, item_q.identity,
								22'(item_q.fragment_size), 5'd0};
						end
					end
				end
				S_FRAG: begin
					// idx_q marks whether the read has landed
					if (idx_q == '0)
						idx_q <= (AW+1)'(1);
					else begin
						state_q <= S_IDLE;
						res_v_q <= 1'b1;
						if (cnt_n >= ram_rdata.expected) begin
							valid_q[sel_q] <= 1'b0;
							res_q <= '{(upd.bad ? ST_COMPLETE_FAIL : ST_COMPLETE_OK),
								item_q.identity, sum_n, 5'd0};
						end else
							res_q <= '{ST_BUFFERED, item_q.identity,
								22'(item_q.fragment_size), 5'd0};
					end
				end
				S_TICKR: state_q <= S_TICKW;
				S_TICKW: begin
					if (valid_q[idx_q[AW-1:0]] && age_n >= timeout_q) begin
						valid_q[idx_q[AW-1:0]] <= 1'b0;
						if (freed_q != 5'd31)
							freed_q <= freed_q + 5'd1;
					end
					if (last_idx) begin
						state_q <= S_IDLE;
						res_v_q <= 1'b1;
						res_q <= '{ST_TICK, 32'd0, 22'd0,
							(valid_q[idx_q[AW-1:0]] && age_n >= timeout_q &&
							 freed_q != 5'd31) ? freed_q + 5'd1 : freed_q};
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_TICKR;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// the FRAG write must be at the selected, live entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FRAG) |-> valid_q[sel_q])
		else $error("update of free context");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("input taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_v_q && out_stall) |=> (res_v_q && $stable(res_q)))
		else $error("result lost");
endmodule
`default_nettype wire
